FILE: hdl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types, codes and default sizes of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

	localparam int unsigned FRAME_COUNT_DEF  = 1024;
	localparam int unsigned WORD_BITS_DEF    = 32;
	localparam int unsigned PAGE_BYTES_DEF   = 4096;
	localparam logic [31:0] MEMORY_BYTES_DEF = 32'd4194304;

	localparam int FRAME_IDX_W = 16;
	localparam int ADDR_W      = 32;
	localparam int GRANT_W     = 10;

	typedef enum logic [1:0] {
		OP_ALLOC_ANY = 2'd0,
		OP_ALLOC_AT  = 2'd1,
		OP_FREE      = 2'd2,
		OP_BOOK      = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_INVALID = 3'd1,
		ST_BUSY    = 3'd2,
		ST_DOUBLE  = 3'd3,
		ST_FULL    = 3'd4,
		ST_SMALL   = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_DIV_BASE,
		S_DIV_END,
		S_SWEEP,
		S_FIN
	} state_t;

	typedef struct packed {
		logic               busy;
		logic               dbl;
		logic               found;
		logic [GRANT_W-1:0] frame;
	} word_flags_t;

endpackage

FILE: hdl/pfba_if.sv
// ----------------------------------------------------------------------------
// pfba_if
// Request and response channels: valid/ready handshake with payload.
// ----------------------------------------------------------------------------
interface pfba_req_if;
	import pfba_pkg::*;

	logic                   valid;
	logic                   ready;
	op_t                    op;
	logic [FRAME_IDX_W-1:0] frame_index;
	logic [ADDR_W-1:0]      range_base;
	logic [ADDR_W-1:0]      range_end;

	modport source (output valid, op, frame_index, range_base, range_end, input ready);
	modport sink   (input valid, op, frame_index, range_base, range_end, output ready);
endinterface

interface pfba_rsp_if;
	import pfba_pkg::*;

	logic               valid;
	logic               ready;
	status_t            status;
	logic [GRANT_W-1:0] granted_frame;

	modport source (output valid, status, granted_frame, input ready);
	modport sink   (input valid, status, granted_frame, output ready);
endinterface

FILE: hdl/pfba_ram.sv
// ----------------------------------------------------------------------------
// pfba_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: hdl/pfba_div.sv
// ----------------------------------------------------------------------------
// pfba_div
// Division by the page size: shift and low-bit test, result registered in the cycle after start.
// The page size must be a power of two; the block itself does not enforce it.
// ----------------------------------------------------------------------------
module pfba_div #(
	parameter int unsigned DIVISOR = pfba_pkg::PAGE_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [pfba_pkg::ADDR_W-1:0] dividend,
	output logic                      done,
	output logic [pfba_pkg::ADDR_W-1:0] quotient,
	output logic                      rem_nz
);
	import pfba_pkg::*;

	localparam int SH = $clog2(DIVISOR);

	logic              done_q;
	logic [ADDR_W-1:0] quot_q;
	logic              rnz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend >> SH;
			rnz_q  <= |dividend[SH-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;
	assign rem_nz   = rnz_q;
endmodule

FILE: hdl/pfba_word.sv
// ----------------------------------------------------------------------------
// pfba_word
// Per-word update: frame window mask, claim/release and lowest-free search.
// ----------------------------------------------------------------------------
module pfba_word #(
	parameter int WORD_BITS = pfba_pkg::WORD_BITS_DEF,
	parameter int FRW       = 18
) (
	input  pfba_pkg::op_t           op,
	input  logic [WORD_BITS-1:0]    word,
	input  logic [FRW-1:0]          fw,
	input  logic [FRW-1:0]          lo_f,
	input  logic [FRW-1:0]          hi_f,
	output logic [WORD_BITS-1:0]    wdata,
	output logic                    we,
	output pfba_pkg::word_flags_t   flags
);
	import pfba_pkg::*;

	localparam int BW = $clog2(WORD_BITS + 1);
	localparam int IW = $clog2(WORD_BITS);

	logic [BW-1:0]        lo_b;
	logic [BW-1:0]        hi_b;
	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] free_bits;
	logic [WORD_BITS-1:0] onehot;
	logic [IW-1:0]        idx;
	logic [FRW-1:0]       frame_full;

	function automatic logic [BW-1:0] rel_pos(input logic [FRW-1:0] x,
			input logic [FRW-1:0] base);
		logic [FRW-1:0] d;
		d = x - base;
		if (x <= base) begin
			return '0;
		end else if (d >= FRW'(WORD_BITS)) begin
			return BW'(WORD_BITS);
		end else begin
			return d[BW-1:0];
		end
	endfunction

	assign lo_b = rel_pos(lo_f, fw);
	assign hi_b = rel_pos(hi_f, fw);

	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			mask[i] = (BW'(i) >= lo_b) && (BW'(i) < hi_b);
		end
	end

	assign free_bits = mask & ~word;

	always_comb begin
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free_bits[i]) begin
				idx = IW'(i);
			end
		end
	end

	assign onehot     = WORD_BITS'(1) << idx;
	assign frame_full = fw + FRW'(idx);

	assign flags.busy  = |(word & mask);
	assign flags.dbl   = |free_bits;
	assign flags.found = |free_bits;
	assign flags.frame = frame_full[GRANT_W-1:0];

	always_comb begin
		unique case (op)
			OP_ALLOC_ANY: begin
				wdata = word | onehot;
				we    = |free_bits;
			end
			OP_FREE: begin
				wdata = word & ~mask;
				we    = |mask;
			end
			OP_ALLOC_AT, OP_BOOK: begin
				wdata = word | mask;
				we    = |mask;
			end
			default: begin
				wdata = word;
				we    = 1'b0;
			end
		endcase
	end
endmodule

FILE: hdl/page_frame_bitmap_allocator_core.sv
// ----------------------------------------------------------------------------
// page_frame_bitmap_allocator_core
// First-fit bitmap page frame allocator; used map held in one RAM.
// ----------------------------------------------------------------------------
// Allocate-any, allocate-specific and free sweep the map one word per cycle through
//   the RAM read/modify/write path; allocate-any stops early.
// Book-range adds page arithmetic (S_DIV_BASE, S_DIV_END) ahead of the sweep.
// An invalid frame or an empty range skips the sweep. One request is handled at a time.
// Reset: a clearing pass writes every map word to zero, no request taken.
module page_frame_bitmap_allocator_core #(
	parameter int unsigned FRAME_COUNT  = pfba_pkg::FRAME_COUNT_DEF,
	parameter int unsigned WORD_BITS    = pfba_pkg::WORD_BITS_DEF,
	parameter int unsigned PAGE_BYTES   = pfba_pkg::PAGE_BYTES_DEF,
	parameter logic [31:0] MEMORY_BYTES = pfba_pkg::MEMORY_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pfba_req_if.sink    req,
	pfba_rsp_if.source  rsp
);
	import pfba_pkg::*;

	localparam int MAP_WORDS = (FRAME_COUNT + WORD_BITS - 1) / WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int CW        = $clog2(MAP_WORDS + 1);
	localparam int FRW_RAW   = 34 - $clog2(PAGE_BYTES);
	localparam int FRW       = (FRW_RAW > 18) ? FRW_RAW : 18;

	localparam logic [FRW-1:0] FC_F      = FRW'(FRAME_COUNT);
	localparam logic [FRW-1:0] WB_F      = FRW'(WORD_BITS);
	localparam logic [AW-1:0]  LAST_ADDR = AW'(MAP_WORDS - 1);
	localparam logic [CW-1:0]  WORDS_C   = CW'(MAP_WORDS);

	state_t state_q, state_d;

	logic                 accept;
	logic [CW-1:0]        w_q;
	logic [FRW-1:0]       fw_q;
	op_t                  op_q;
	logic [FRW-1:0]       lo_q;
	logic [FRW-1:0]       hi_q;
	logic [FRW-1:0]       first_q;
	logic [ADDR_W-1:0]    end_q;
	logic                 busy_q;
	logic                 dbl_q;
	logic                 inval_q;
	status_t              res_status_q;
	logic [GRANT_W-1:0]   res_frame_q;

	logic                 rd_valid_s1;
	logic [AW-1:0]        rd_addr_s1;
	logic [FRW-1:0]       rd_fw_s1;

	logic                 rsp_valid_q;
	status_t              rsp_status_q;
	logic [GRANT_W-1:0]   rsp_frame_q;
	logic                 rsp_load;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr;
	logic [WORD_BITS-1:0] ram_wdata;
	logic                 ram_re;
	logic [AW-1:0]        ram_raddr;
	logic [WORD_BITS-1:0] ram_rdata;

	logic                 div_start;
	logic [ADDR_W-1:0]    div_dividend;
	logic                 div_done;
	logic [ADDR_W-1:0]    div_quot;
	logic                 div_rnz;
	logic [FRW-1:0]       last_f;

	logic [WORD_BITS-1:0] wu_wdata;
	logic                 wu_we;
	word_flags_t          wflags;

	logic                 sweep_done;
	logic                 frame_bad;
	logic [ADDR_W-1:0]    end_clamp;
	status_t              done_status;
	logic [GRANT_W-1:0]   done_frame;

	pfba_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (MAP_WORDS),
		.AW    (AW)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pfba_div #(
		.DIVISOR (PAGE_BYTES)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.done     (div_done),
		.quotient (div_quot),
		.rem_nz   (div_rnz)
	);

	pfba_word #(
		.WORD_BITS (WORD_BITS),
		.FRW       (FRW)
	) u_word (
		.op    (op_q),
		.word  (ram_rdata),
		.fw    (rd_fw_s1),
		.lo_f  (lo_q),
		.hi_f  (hi_q),
		.wdata (wu_wdata),
		.we    (wu_we),
		.flags (wflags)
	);

	assign accept     = req.valid && req.ready;
	assign frame_bad  = (FRW'(req.frame_index) >= FC_F);
	assign end_clamp  = (req.range_end > MEMORY_BYTES) ? MEMORY_BYTES : req.range_end;
	assign last_f     = div_quot[FRW-1:0];
	assign sweep_done = (state_q == S_SWEEP) && rd_valid_s1 &&
		((rd_addr_s1 == LAST_ADDR) || ((op_q == OP_ALLOC_ANY) && wflags.found));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (w_q[AW-1:0] == LAST_ADDR) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					unique case (req.op)
						OP_ALLOC_ANY:         state_d = S_SWEEP;
						OP_ALLOC_AT, OP_FREE: state_d = frame_bad ? S_FIN : S_SWEEP;
						OP_BOOK:              state_d = S_DIV_BASE;
						default:              state_d = S_IDLE;
					endcase
				end
			end
			S_DIV_BASE: begin
				if (div_done) begin
					state_d = S_DIV_END;
				end
			end
			S_DIV_END: begin
				if (div_done) begin
					state_d = (last_f <= first_q) ? S_FIN : S_SWEEP;
				end
			end
			S_SWEEP: begin
				if (sweep_done) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (rsp_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		req.ready    = 1'b0;
		ram_we       = 1'b0;
		ram_waddr    = rd_addr_s1;
		ram_wdata    = wu_wdata;
		ram_re       = 1'b0;
		ram_raddr    = w_q[AW-1:0];
		div_start    = 1'b0;
		div_dividend = req.range_base;
		rsp_load     = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = w_q[AW-1:0];
				ram_wdata = '0;
			end
			S_IDLE: begin
				req.ready = 1'b1;
				div_start = req.valid && (req.op == OP_BOOK);
			end
			S_DIV_BASE: begin
				div_start    = div_done;
				div_dividend = end_q;
			end
			S_DIV_END: begin
			end
			S_SWEEP: begin
				ram_re = (w_q != WORDS_C) && !sweep_done;
				ram_we = rd_valid_s1 && wu_we;
			end
			S_FIN: begin
				rsp_load = !rsp_valid_q || rsp.ready;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		done_status = ST_OK;
		done_frame  = '0;
		unique case (op_q)
			OP_ALLOC_ANY: begin
				if (wflags.found) begin
					done_frame = wflags.frame;
				end else begin
					done_status = ST_FULL;
				end
			end
			OP_ALLOC_AT: begin
				if (busy_q || wflags.busy) begin
					done_status = ST_BUSY;
				end
			end
			OP_FREE: begin
				if (dbl_q || wflags.dbl) begin
					done_status = ST_DOUBLE;
				end
			end
			OP_BOOK: begin
				if (busy_q || wflags.busy) begin
					done_status = ST_BUSY;
				end else if (inval_q) begin
					done_status = ST_INVALID;
				end
			end
			default: done_status = ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			w_q         <= '0;
			fw_q        <= '0;
			rd_valid_s1 <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= ram_re;
			case (state_q)
				S_CLEAR: w_q <= (w_q[AW-1:0] == LAST_ADDR) ? '0 : w_q + CW'(1);
				S_IDLE: begin
					w_q  <= '0;
					fw_q <= '0;
				end
				S_SWEEP: begin
					if (ram_re) begin
						w_q  <= w_q + CW'(1);
						fw_q <= fw_q + WB_F;
					end
				end
				default: begin
				end
			endcase
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q         <= req.op;
			busy_q       <= 1'b0;
			dbl_q        <= 1'b0;
			inval_q      <= 1'b0;
			end_q        <= end_clamp;
			res_status_q <= ST_INVALID;
			res_frame_q  <= '0;
			if (req.op == OP_ALLOC_ANY) begin
				lo_q <= '0;
				hi_q <= FC_F;
			end else begin
				lo_q <= FRW'(req.frame_index);
				hi_q <= FRW'(req.frame_index) + FRW'(1);
			end
		end
		if (state_q == S_DIV_BASE && div_done) begin
			first_q <= last_f + FRW'(div_rnz);
		end
		if (state_q == S_DIV_END && div_done) begin
			lo_q         <= first_q;
			hi_q         <= (last_f > FC_F) ? FC_F : last_f;
			inval_q      <= (last_f > FC_F);
			res_status_q <= ST_SMALL;
		end
		if (ram_re) begin
			rd_addr_s1 <= ram_raddr;
			rd_fw_s1   <= fw_q;
		end
		if (state_q == S_SWEEP && rd_valid_s1) begin
			busy_q <= busy_q | wflags.busy;
			dbl_q  <= dbl_q | wflags.dbl;
		end
		if (sweep_done) begin
			res_status_q <= done_status;
			res_frame_q  <= done_frame;
		end
		if (rsp_load) begin
			rsp_status_q <= res_status_q;
			rsp_frame_q  <= res_frame_q;
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.granted_frame = rsp_frame_q;

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("map read and write hit the same word");

	a_no_stray_read: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(state_q == S_SWEEP) |-> !rd_valid_s1)
		else $error("map read still in flight after sweep end");

	a_grant_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.granted_frame == '0))
		else $error("granted frame set on failed transfer");
endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the page frame bitmap allocator. A scoreboard keeps
// its own copy of the used map, works out each reply as a request transfer is
// taken, and compares replies in order. Directed corner cases come first, then
// random traffic that alternates between filling and draining the map, under
// several sender and receiver idling patterns.
// ----------------------------------------------------------------------------
module tb;
	import pfba_pkg::*;

	localparam int unsigned FRAMES      = FRAME_COUNT_DEF;
	localparam int unsigned PAGE_SZ     = PAGE_BYTES_DEF;
	localparam int unsigned MEM_SZ      = MEMORY_BYTES_DEF;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;
	localparam int unsigned PHASE_ITEMS = 407;

	typedef struct {
		status_t            status;
		logic [GRANT_W-1:0] frame;
	} reply_t;

	class frame_map_scoreboard;
		bit     in_use [FRAMES];
		reply_t awaited [$];
		int     errors;

		function new();
			foreach (in_use[i])
				in_use[i] = 1'b0;
			errors = 0;
		endfunction

		function int pending();
			return awaited.size();
		endfunction

		function int unsigned some_used_frame();
			int unsigned start;
			start = $urandom_range(0, FRAMES - 1);
			for (int unsigned k = 0; k < FRAMES; k++)
				if (in_use[(start + k) % FRAMES])
					return (start + k) % FRAMES;
			return start;
		endfunction

		function status_t book_window(logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] stop);
			longint unsigned lo, hi, first, last;
			bit              hit_busy, past_map;
			hit_busy = 1'b0;
			past_map = 1'b0;
			hi = stop;
			if (hi > MEM_SZ)
				hi = MEM_SZ;
			lo = base;
			lo = ((lo + PAGE_SZ - 1) / PAGE_SZ) * PAGE_SZ;
			hi = (hi / PAGE_SZ) * PAGE_SZ;
			if (hi <= lo)
				return ST_SMALL;
			first = lo / PAGE_SZ;
			last  = hi / PAGE_SZ;
			if (last > FRAMES) begin
				past_map = 1'b1;
				last     = FRAMES;
			end
			for (longint unsigned f = first; f < last; f++) begin
				if (in_use[f])
					hit_busy = 1'b1;
				else
					in_use[f] = 1'b1;
			end
			if (hit_busy)
				return ST_BUSY;
			if (past_map)
				return ST_INVALID;
			return ST_OK;
		endfunction

		function void note_request(op_t op, logic [FRAME_IDX_W-1:0] idx,
				logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] stop);
			reply_t r;
			r.status = ST_OK;
			r.frame  = '0;
			case (op)
			OP_ALLOC_ANY: begin
				r.status = ST_FULL;
				for (int unsigned f = 0; f < FRAMES; f++) begin
					if (!in_use[f]) begin
						in_use[f] = 1'b1;
						r.status  = ST_OK;
						r.frame   = GRANT_W'(f);
						break;
					end
				end
			end
			OP_ALLOC_AT: begin
				if (idx >= FRAMES)
					r.status = ST_INVALID;
				else if (in_use[idx])
					r.status = ST_BUSY;
				else
					in_use[idx] = 1'b1;
			end
			OP_FREE: begin
				if (idx >= FRAMES)
					r.status = ST_INVALID;
				else if (!in_use[idx])
					r.status = ST_DOUBLE;
				else
					in_use[idx] = 1'b0;
			end
			default: begin
				r.status = book_window(base, stop);
			end
			endcase
			awaited.push_back(r);
		endfunction

		task log_mismatch(string what, int got, int want);
			errors++;
			$display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		endtask

		task check_response(status_t st, logic [GRANT_W-1:0] fr);
			reply_t e;
			if (awaited.size() == 0) begin
				log_mismatch("reply with nothing outstanding", int'(st), -1);
				return;
			end
			e = awaited.pop_front();
			if (st !== e.status)
				log_mismatch("status", int'(st), int'(e.status));
			if (fr !== e.frame)
				log_mismatch("granted_frame", int'(fr), int'(e.frame));
		endtask
	endclass

	logic                clk;
	logic                arst_n;
	int unsigned         send_idle_pct;
	int unsigned         recv_stall_pct;
	int unsigned         cycle_count = 0;
	frame_map_scoreboard sb;

	pfba_req_if req_ch();
	pfba_rsp_if rsp_ch();

	page_frame_bitmap_allocator_core DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(negedge clk)
		rsp_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);

	always @(posedge clk)
		if (arst_n && rsp_ch.valid && rsp_ch.ready)
			sb.check_response(rsp_ch.status, rsp_ch.granted_frame);

	task automatic send_request(op_t op, logic [FRAME_IDX_W-1:0] idx,
			logic [ADDR_W-1:0] base, logic [ADDR_W-1:0] stop);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid       = 1'b1;
		req_ch.op          = op;
		req_ch.frame_index = idx;
		req_ch.range_base  = base;
		req_ch.range_end   = stop;
		do
			@(posedge clk);
		while (!req_ch.ready);
		sb.note_request(op, idx, base, stop);
		@(negedge clk);
	endtask

	task automatic wait_quiet(int unsigned settle);
		req_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	// filling favours claims, draining favours frees of frames known to be used
	task automatic random_request(bit filling);
		int unsigned             pick, sel;
		op_t                     op;
		logic [FRAME_IDX_W-1:0]  idx;
		logic [ADDR_W-1:0]       base, stop;
		pick = $urandom_range(0, 99);
		if (filling) begin
			if (pick < 40)      op = OP_ALLOC_ANY;
			else if (pick < 60) op = OP_ALLOC_AT;
			else if (pick < 75) op = OP_FREE;
			else                op = OP_BOOK;
		end else begin
			if (pick < 15)      op = OP_ALLOC_ANY;
			else if (pick < 25) op = OP_ALLOC_AT;
			else if (pick < 85) op = OP_FREE;
			else                op = OP_BOOK;
		end

		sel = $urandom_range(0, 99);
		if (op == OP_FREE && sel < 60)
			idx = FRAME_IDX_W'(sb.some_used_frame());
		else if (sel < 80)
			idx = FRAME_IDX_W'($urandom_range(0, FRAMES - 1));
		else if (sel < 95)
			idx = FRAME_IDX_W'($urandom());
		else begin
			case ($urandom_range(0, 3))
			0:       idx = '0;
			1:       idx = FRAME_IDX_W'(FRAMES - 1);
			2:       idx = FRAME_IDX_W'(FRAMES);
			default: idx = '1;
			endcase
		end

		sel = $urandom_range(0, 99);
		if (sel < 70) begin
			base = $urandom_range(0, MEM_SZ + 4 * PAGE_SZ);
			stop = base + $urandom_range(0, 24 * PAGE_SZ);
		end else if (sel < 98) begin
			base = $urandom();
			stop = $urandom();
		end else begin
			base = $urandom_range(0, 8 * PAGE_SZ);
			stop = $urandom();
		end
		send_request(op, idx, base, stop);
	endtask

	initial begin
		sb                 = new();
		arst_n             = 1'b0;
		send_idle_pct      = 0;
		recv_stall_pct     = 0;
		req_ch.valid       = 1'b0;
		req_ch.op          = OP_ALLOC_ANY;
		req_ch.frame_index = '0;
		req_ch.range_base  = '0;
		req_ch.range_end   = '0;
		rsp_ch.ready       = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_request(OP_ALLOC_ANY, '0, '0, '0);
		send_request(OP_ALLOC_ANY, '1, '1, '1);
		send_request(OP_ALLOC_AT, '0, '0, '0);
		send_request(OP_ALLOC_AT, FRAME_IDX_W'(FRAMES - 1), '0, '0);
		send_request(OP_ALLOC_AT, FRAME_IDX_W'(FRAMES), '0, '0);
		send_request(OP_ALLOC_AT, '1, '0, '0);
		send_request(OP_FREE, '0, '0, '0);
		send_request(OP_FREE, '0, '0, '0);
		send_request(OP_FREE, FRAME_IDX_W'(FRAMES), '0, '0);
		send_request(OP_FREE, '1, '0, '0);
		send_request(OP_ALLOC_ANY, '0, '0, '0);
		send_request(OP_BOOK, '0, '0, '0);
		// base rounds up past the top of the address space
		send_request(OP_BOOK, '0, '1, '1);
		send_request(OP_BOOK, '0, PAGE_SZ + 1, 2 * PAGE_SZ - 1);
		send_request(OP_BOOK, '0, 32'd1, 2 * PAGE_SZ);
		send_request(OP_BOOK, '0, 2 * PAGE_SZ, 4 * PAGE_SZ);
		// end clamped to memory size
		send_request(OP_BOOK, '0, MEM_SZ - PAGE_SZ, '1);
		send_request(OP_FREE, FRAME_IDX_W'(FRAMES - 1), '0, '0);
		send_request(OP_BOOK, '0, MEM_SZ - PAGE_SZ, '1);
		send_request(OP_BOOK, '0, '0, '1);
		send_request(OP_ALLOC_ANY, '0, '0, '0);
		send_request(OP_FREE, FRAME_IDX_W'(FRAMES / 2), '0, '0);
		send_request(OP_ALLOC_ANY, '0, '0, '0);
		send_request(OP_ALLOC_ANY, '0, '0, '0);
		send_request(OP_FREE, FRAME_IDX_W'(5), '0, '0);
		wait_quiet(8);

		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
			default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++)
				random_request((n / 60) % 2 == 1);
			wait_quiet(8);
		end

		wait_quiet(120);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
